// ===== hw/rtl/insertion_sorter_assert.svh =====
// Assertion macros for the insertion sorter.
// Used by insertion_sorter.sv; empty bodies when SYNTH is defined.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH
`ifndef SYNTH
`define ISORT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("insertion_sorter: assertion failed");
`define ISORT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("insertion_sorter: assertion failed");
`else
`define ISORT_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISORT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/isort_pkg.sv =====
// Package for the insertion sorter: widths, default capacity, cell control type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isort_pkg;
   localparam int DATA_W           = 32;
   localparam int DEFAULT_CAPACITY = 32;

   typedef struct packed {
      logic                     insert;
      logic                     drain;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ===== hw/rtl/isort_cell.sv =====
// One cell of the sorting chain: holds one value, compares against the broadcast input.
// Depends on isort_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isort_cell
   import isort_pkg::*;
(
   input  wire logic                     clock,
   input  wire cell_ctrl_type            ctrl,
   input  wire logic                     occupied,
   input  wire logic                     left_keep,
   input  wire logic signed [DATA_W-1:0] left_value,
   input  wire logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0]      value,
   output logic                          keep
);
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   assign keep  = occupied && (value_ff < ctrl.value);
   assign value = value_ff;

   always_comb begin
      priority if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert && !keep) begin
         value_in = left_keep ? ctrl.value : left_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/insertion_sorter.sv =====
// Channel  | Ports                                   | Direction
// req      | req_valid, req_stall, req_value, req_last_in | in (stall out)
// rsp      | rsp_valid, rsp_stall, rsp_sorted_value, rsp_last_out, rsp_dropped | out
// One value is inserted per cycle: every cell compares in parallel and shifts up by one.
// A transfer with req_last_in starts a drain of all held values, one result per
// cycle through the output register; req_stall is high for the whole drain.
// rsp_stall holds the drain in place. Reset clears count, overflow, drain and output valid.
// Depends on isort_pkg, isort_cell and insertion_sorter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "insertion_sorter_assert.svh"
module insertion_sorter
   import isort_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_last_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_last_out,
   output logic                          rsp_dropped
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     overflow_ff, overflow_in;
   logic                     drain_ff, drain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   logic                     accept, full, advance;
   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     cell_keep  [CAPACITY];
   logic signed [DATA_W-1:0] left_value [CAPACITY];
   logic signed [DATA_W-1:0] right_value[CAPACITY];
   logic                     left_keep  [CAPACITY];

   assign req_stall = drain_ff;
   assign accept    = req_valid && !drain_ff;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign advance   = drain_ff && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.insert = accept && !full;
   assign ctrl.drain  = advance;
   assign ctrl.value  = req_value;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         left_keep[i]   = (i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1];
         left_value[i]  = (i == 0) ? req_value : cell_value[(i == 0) ? 0 : i - 1];
         right_value[i] = (i == CAPACITY - 1) ? cell_value[i]
                        : cell_value[(i == CAPACITY - 1) ? i : i + 1];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      isort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CNT_W'(i)),
         .left_keep   (left_keep[i]),
         .left_value  (left_value[i]),
         .right_value (right_value[i]),
         .value       (cell_value[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      priority if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = cell_value[0];
         rsp_last_in  = count_ff == CNT_W'(1);
         rsp_drop_in  = overflow_ff;
         count_in     = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            drain_in    = 1'b0;
            overflow_in = 1'b0;
         end
      end else if (accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         drain_in = req_last_in;
      end else begin
         drain_in = drain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_dropped      = rsp_drop_ff;

   `ISORT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ISORT_ASSERT_IMP(a_drain_nonempty, clock, reset, drain_ff, count_ff != '0)
   `ISORT_ASSERT_NXT(a_last_drains, clock, reset, accept && req_last_in, drain_ff)
   `ISORT_ASSERT_IMP(a_drain_clears, clock, reset, $fell(drain_ff),
                     count_ff == '0 && !overflow_ff && rsp_valid_ff && rsp_last_ff)
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for insertion_sorter: directed table, then random sequences.
// Depends on isort_pkg and the insertion_sorter RTL; results checked against a local sort model.
`timescale 1ns / 1ps
module tb;
   import isort_pkg::*;

   localparam int CAP         = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     dropped;
   } sorted_entry_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_in;
      logic                     typed;
      logic signed [DATA_W-1:0] out_value;
      logic                     out_last;
      logic                     out_dropped;
   } stim_row_t;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_value;
   logic                     req_last_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_dropped;

   int cycle_count = 0;
   int mismatches  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;

   // local sort model
   logic signed [DATA_W-1:0] kept_vals [CAP];
   int                       kept_count    = 0;
   logic                     kept_overflow = 1'b0;
   sorted_entry_t            drain_due [$];

   stim_row_t directed_rows [24];

   insertion_sorter #(.CAPACITY(CAP)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_dropped      (rsp_dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout at cycle %0d", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic insert_or_drain(input logic signed [DATA_W-1:0] v, input logic last_in);
      int            pos;
      sorted_entry_t e;
      if (kept_count < CAP) begin
         pos = 0;
         while (pos < kept_count && kept_vals[pos] < v) pos++;
         for (int k = kept_count; k > pos; k--) kept_vals[k] = kept_vals[k-1];
         kept_vals[pos] = v;
         kept_count++;
      end else begin
         kept_overflow = 1'b1;
      end
      if (last_in) begin
         for (int k = 0; k < kept_count; k++) begin
            e.value   = kept_vals[k];
            e.last    = (k == kept_count - 1);
            e.dropped = kept_overflow;
            drain_due.push_back(e);
         end
         kept_count    = 0;
         kept_overflow = 1'b0;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      sorted_entry_t due;
      if (reset === 1'b0 && rsp_valid !== 1'b0 && rsp_stall === 1'b0) begin
         if (drain_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_sorted_value));
         end else begin
            due = drain_due.pop_front();
            if (rsp_valid !== 1'b1)
               report_mismatch("rsp_valid unknown");
            if (rsp_sorted_value !== due.value)
               report_mismatch($sformatf("sorted_value %0d, want %0d",
                                         rsp_sorted_value, due.value));
            if (rsp_last_out !== due.last)
               report_mismatch($sformatf("last_out %b, want %b", rsp_last_out, due.last));
            if (rsp_dropped !== due.dropped)
               report_mismatch($sformatf("dropped %b, want %b", rsp_dropped, due.dropped));
         end
      end
   end

   // holds the payload until the transfer, then an optional sender gap
   task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last_in,
                            input stim_row_t row);
      int gap;
      req_valid   <= 1'b1;
      req_value   <= v;
      req_last_in <= last_in;
      do @(posedge clock); while (req_stall !== 1'b0);
      insert_or_drain(v, last_in);
      if (row.typed)
         drain_due[drain_due.size()-1] = '{row.out_value, row.out_last, row.out_dropped};
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (drain_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3:    return int'($urandom_range(15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(8, 1);
      if (r < 95) return $urandom_range(32, 9);
      return $urandom_range(40, 33);
   endfunction

   task automatic run_phase(input int idle, input int stall, input int items,
                            input int first_len);
      int sent;
      int len;
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < items) begin
         len = (sent == 0 && first_len > 0) ? first_len : pick_length();
         for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1, '0);
         sent += len;
      end
      pause_until_drained();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_value   <= '0;
      req_last_in <= 1'b0;
      rsp_stall   <= 1'b0;

      directed_rows = '{
         '{32'sd5,        1'b1, 1'b1, 32'sd5,   1'b1, 1'b0},
         '{VAL_MIN,       1'b1, 1'b1, VAL_MIN,  1'b1, 1'b0},
         '{VAL_MAX,       1'b1, 1'b1, VAL_MAX,  1'b1, 1'b0},
         '{32'sd0,        1'b1, 1'b1, 32'sd0,   1'b1, 1'b0},
         '{-32'sd1,       1'b1, 1'b1, -32'sd1,  1'b1, 1'b0},
         '{VAL_MAX,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{VAL_MIN,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd0,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{-32'sd1,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd1,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd7,        1'b1, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd3,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd3,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd3,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd3,        1'b1, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd10,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd9,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd8,        1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'sd7,        1'b1, 1'b0, '0, 1'b0, 1'b0},
         '{-32'sd5,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{-32'sd4,       1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{-32'sd3,       1'b1, 1'b0, '0, 1'b0, 1'b0},
         '{32'sh55555555, 1'b0, 1'b0, '0, 1'b0, 1'b0},
         '{32'shAAAAAAAA, 1'b1, 1'b0, '0, 1'b0, 1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].value, directed_rows[i].last_in, directed_rows[i]);
      pause_until_drained();

      // full store without drops, idle gaps, full plus dropped last, deep overflow
      run_phase(0,  0,  60, CAP);
      run_phase(57, 0,  60, 0);
      run_phase(0,  57, 60, CAP + 1);
      run_phase(8,  8,  55, CAP + 8);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && drain_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/isort_pkg.sv
hw/rtl/isort_cell.sv
hw/rtl/insertion_sorter.sv
sim/tb.sv
